### sv/bald_pkg.sv
package bald_pkg;

   // Default sizing of the list.
   localparam int CAPACITY_DEF   = 256;
   localparam int ENTRY_BITS_DEF = 32;

   // Fixed field widths of the request and response transactions.
   localparam int DATA_W  = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 9;
   localparam int WIDE_W  = 64;
   localparam int ACT_W   = 3;
   localparam int STAT_W  = 2;
   localparam int TDATA_W = 48;

   // Bit offsets inside req_tdata.
   localparam int REQ_ACT_LSB  = 0;
   localparam int REQ_DATA_LSB = REQ_ACT_LSB + ACT_W;
   localparam int REQ_POS_LSB  = REQ_DATA_LSB + DATA_W;
   localparam int REQ_USED_W   = REQ_POS_LSB + POS_W;

   // Bits of rsp_tdata above the packed fields.
   localparam int RSP_USED_W = DATA_W + STAT_W + COUNT_W;
   localparam int RSP_PAD_W  = TDATA_W - RSP_USED_W;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT_HEAD = 3'd0,
      ACT_INSERT_TAIL = 3'd1,
      ACT_REMOVE_HEAD = 3'd2,
      ACT_REMOVE_TAIL = 3'd3,
      ACT_READ_INDEX  = 3'd4,
      ACT_READ_HEAD   = 3'd5,
      ACT_READ_TAIL   = 3'd6
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // What a request leaves for its response besides the entry read.
   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
      logic                 rd_hit;
   } result_meta_type;

endpackage

### sv/bald_ring_ram.sv
module bald_ring_ram #(
   parameter int DEPTH  = bald_pkg::CAPACITY_DEF,
   parameter int WIDTH  = bald_pkg::ENTRY_BITS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single-port store with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bald_ctrl.sv
module bald_ctrl #(
   parameter int CAPACITY   = bald_pkg::CAPACITY_DEF,
   parameter int ENTRY_BITS = bald_pkg::ENTRY_BITS_DEF,
   parameter int PTR_W      = $clog2(CAPACITY)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [bald_pkg::ACT_W-1:0]       action,
   input  logic [ENTRY_BITS-1:0]            entry_word,
   input  logic [bald_pkg::POS_W-1:0]       position,
   output logic                             mem_we,
   output logic                             mem_re,
   output logic [PTR_W-1:0]                 mem_addr,
   output logic [ENTRY_BITS-1:0]            mem_wdata,
   output bald_pkg::result_meta_type        meta
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (bald_pkg::POS_W > CNT_W) ? bald_pkg::POS_W : CNT_W;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                 full, empty, pos_ok;
   logic [PTR_W-1:0]     head_dec, head_inc, off, ring_addr;
   logic [PTR_W:0]       ring_sum;
   logic [CMP_W-1:0]     pos_ext, cnt_ext;
   logic [CNT_W-1:0]     count_m1;
   logic                 we, re, use_head_dec;
   bald_pkg::status_type status;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign count_m1 = count_ff - CNT_W'(1);
   assign pos_ext  = CMP_W'(position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign pos_ok   = (pos_ext < cnt_ext);

   // Neighbors of the head on the ring.
   assign head_dec = (head_ff == '0) ? PTR_W'(CAPACITY - 1) : head_ff - PTR_W'(1);
   assign head_inc = (head_ff == PTR_W'(CAPACITY - 1)) ? '0 : head_ff + PTR_W'(1);

   // Ring position of an offset from the head; the offset is below the capacity.
   assign ring_sum  = {1'b0, head_ff} + {1'b0, off};
   assign ring_addr = (ring_sum >= (PTR_W + 1)'(CAPACITY)) ?
                      PTR_W'(ring_sum - (PTR_W + 1)'(CAPACITY)) : ring_sum[PTR_W-1:0];

   // Decode of the request against the current head and count.
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      we           = 1'b0;
      re           = 1'b0;
      use_head_dec = 1'b0;
      off          = '0;
      status       = bald_pkg::ST_OK;
      unique case (bald_pkg::action_type'(action))
         bald_pkg::ACT_INSERT_HEAD: begin
            if (full) begin
               status = bald_pkg::ST_FULL;
            end else begin
               we           = 1'b1;
               use_head_dec = 1'b1;
               head_in      = head_dec;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         bald_pkg::ACT_INSERT_TAIL: begin
            if (full) begin
               status = bald_pkg::ST_FULL;
            end else begin
               we       = 1'b1;
               off      = count_ff[PTR_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
         end
         bald_pkg::ACT_REMOVE_HEAD: begin
            if (empty) begin
               status = bald_pkg::ST_EMPTY;
            end else begin
               head_in  = head_inc;
               count_in = count_m1;
            end
         end
         bald_pkg::ACT_REMOVE_TAIL: begin
            if (empty) begin
               status = bald_pkg::ST_EMPTY;
            end else begin
               count_in = count_m1;
            end
         end
         bald_pkg::ACT_READ_INDEX: begin
            if (pos_ok) begin
               re  = 1'b1;
               off = pos_ext[PTR_W-1:0];
            end else begin
               status = bald_pkg::ST_RANGE;
            end
         end
         bald_pkg::ACT_READ_HEAD: begin
            if (empty) begin
               status = bald_pkg::ST_RANGE;
            end else begin
               re = 1'b1;
            end
         end
         bald_pkg::ACT_READ_TAIL: begin
            if (empty) begin
               status = bald_pkg::ST_RANGE;
            end else begin
               re  = 1'b1;
               off = count_m1[PTR_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign mem_we    = take & we;
   assign mem_re    = take & re;
   assign mem_addr  = use_head_dec ? head_dec : ring_addr;
   assign mem_wdata = entry_word;

   assign meta.status = status;
   assign meta.count  = bald_pkg::COUNT_W'(count_in);
   assign meta.rd_hit = re;

   // Head pointer and count advance once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (take) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/bounded_array_list_deque_unit.sv
// A request transaction, once accepted, is registered in the memory stage and then in the
// response register, which presents the response; both stages hold while the response side stalls.
// Throughput: one request per cycle while the response side keeps up; every request
// touches at most one entry of the single-port entry store, in the cycle of acceptance.
// Reset (synchronous, active high) empties the list: count and head pointer go to zero.
module bounded_array_list_deque_unit #(
   parameter int CAPACITY   = bald_pkg::CAPACITY_DEF,
   parameter int ENTRY_BITS = bald_pkg::ENTRY_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0 up: action[2:0], entry_data[31:0], position[7:0], zero pad.
   input  logic [bald_pkg::TDATA_W-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0 up: entry_out[31:0], status[1:0], count[8:0], zero pad.
   output logic [bald_pkg::TDATA_W-1:0]   rsp_tdata
);

   localparam int PTR_W = $clog2(CAPACITY);

   logic                          take, s1_move;
   logic [bald_pkg::WIDE_W-1:0]   in_wide, rd_wide;
   logic [ENTRY_BITS-1:0]         entry_word, mem_wdata, mem_rdata;
   logic                          mem_we, mem_re;
   logic [PTR_W-1:0]              mem_addr;
   bald_pkg::result_meta_type     meta;

   logic                          s1_valid_ff, s1_valid_in;
   bald_pkg::result_meta_type     s1_meta_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bald_pkg::DATA_W-1:0]   rsp_entry_ff, rsp_entry_in;
   bald_pkg::status_type          rsp_status_ff;
   logic [bald_pkg::COUNT_W-1:0]  rsp_count_ff;

   // The memory stage moves on whenever the response register is free or drained.
   assign s1_move    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_move;
   assign take       = req_tvalid & req_tready;

   assign in_wide    = bald_pkg::WIDE_W'(req_tdata[bald_pkg::REQ_DATA_LSB +: bald_pkg::DATA_W]);
   assign entry_word = in_wide[ENTRY_BITS-1:0];

   bald_ctrl #(
      .CAPACITY   (CAPACITY),
      .ENTRY_BITS (ENTRY_BITS),
      .PTR_W      (PTR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .action     (req_tdata[bald_pkg::REQ_ACT_LSB +: bald_pkg::ACT_W]),
      .entry_word (entry_word),
      .position   (req_tdata[bald_pkg::REQ_POS_LSB +: bald_pkg::POS_W]),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .meta       (meta)
   );

   bald_ring_ram #(
      .DEPTH   (CAPACITY),
      .WIDTH   (ENTRY_BITS),
      .ADDR_W  (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Read data holds while the memory stage waits, since the store reads only on acceptance.
   assign rd_wide      = bald_pkg::WIDE_W'(mem_rdata);
   assign rsp_entry_in = s1_meta_ff.rd_hit ? rd_wide[bald_pkg::DATA_W-1:0] : '0;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the memory stage and the response register.
   always_ff @(posedge clock) begin
      if (take) begin
         s1_meta_ff <= meta;
      end
      if (s1_move) begin
         rsp_entry_ff  <= rsp_entry_in;
         rsp_status_ff <= s1_meta_ff.status;
         rsp_count_ff  <= s1_meta_ff.count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{bald_pkg::RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_status_ff, rsp_entry_ff};

endmodule
